[rtl/siphash24_envelope_mac_check_defines.svh]
// assertion macros for the siphash mac checker
// expects clk and arst_n in the scope of the module that uses them
`ifndef SIPHASH24_ENVELOPE_MAC_CHECK_DEFINES_SVH
`define SIPHASH24_ENVELOPE_MAC_CHECK_DEFINES_SVH
`ifndef SYNTHESIS
`define SIPMAC_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define SIPMAC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) else $error(msg);
`else
`define SIPMAC_ASSERT(lbl, expr, msg)
`define SIPMAC_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

[rtl/sipmac_pkg.sv]
// shared types, constants and round functions of the siphash mac checker
// no dependencies
package sipmac_pkg;

	localparam int KEY_SLOTS_DEF = 256;
	localparam int KC_W          = 9;
	localparam int SID_W         = 32;
	localparam int REM_BITS      = 4;
	localparam int REM_CELLS     = SID_W / REM_BITS;
	localparam int C_ROUNDS      = 2;
	localparam int D_ROUNDS      = 4;
	localparam int MSG_WORDS     = 3;
	localparam int ROUNDS        = C_ROUNDS * (MSG_WORDS + 1) + D_ROUNDS;
	localparam int MSG_LEN       = 24;
	localparam int FIFO_DEPTH    = 32;
	localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

	localparam logic [63:0] SIP_C0   = 64'h736f6d6570736575;
	localparam logic [63:0] SIP_C1   = 64'h646f72616e646f6d;
	localparam logic [63:0] SIP_C2   = 64'h6c7967656e657261;
	localparam logic [63:0] SIP_C3   = 64'h7465646279746573;
	localparam logic [63:0] FIN_XOR  = 64'h00000000000000ff;
	localparam logic [63:0] LAST_MSG = {8'(MSG_LEN), 56'd0};

	typedef enum logic {
		CMD_LOAD   = 1'b0,
		CMD_VERIFY = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		RSN_OK       = 2'd0,
		RSN_NO_KEYS  = 2'd1,
		RSN_ZERO_KEY = 2'd2,
		RSN_MISMATCH = 2'd3
	} reason_t;

	typedef struct packed {
		cmd_t        command;
		logic [7:0]  key_slot;
		logic [63:0] key_low_word;
		logic [63:0] key_high_word;
		logic [63:0] wire_tag;
		logic [63:0] header_word0;
		logic [63:0] header_word1;
		logic [63:0] header_word2;
	} req_t;

	typedef struct packed {
		logic        accept;
		reason_t     verdict_reason;
		logic [63:0] computed_tag;
	} rsp_t;

	typedef logic [3:0][63:0] sip_state_t;

	// what travels beside the hash state through the round cells
	typedef struct packed {
		logic        nokeys;
		logic        zero_key;
		logic [63:0] wire_tag;
		logic [63:0] w0;
		logic [63:0] w1;
		logic [63:0] w2;
	} side_t;

	function automatic logic [63:0] rotl(logic [63:0] x, int unsigned n);
		return (x << n) | (x >> (64 - n));
	endfunction

	function automatic sip_state_t sip_round(sip_state_t s);
		sip_state_t r;
		r = s;
		r[0] = r[0] + r[1];
		r[1] = rotl(r[1], 13) ^ r[0];
		r[0] = rotl(r[0], 32);
		r[2] = r[2] + r[3];
		r[3] = rotl(r[3], 16) ^ r[2];
		r[0] = r[0] + r[3];
		r[3] = rotl(r[3], 21) ^ r[0];
		r[2] = r[2] + r[1];
		r[1] = rotl(r[1], 17) ^ r[2];
		r[2] = rotl(r[2], 32);
		return r;
	endfunction

	// message mixing at a boundary between round cells, done = rounds finished so far
	function automatic sip_state_t sip_inject(sip_state_t s, side_t d, int unsigned done);
		sip_state_t r;
		r = s;
		if (done == C_ROUNDS) begin
			r[0] = r[0] ^ d.w0;
			r[3] = r[3] ^ d.w1;
		end else if (done == 2 * C_ROUNDS) begin
			r[0] = r[0] ^ d.w1;
			r[3] = r[3] ^ d.w2;
		end else if (done == 3 * C_ROUNDS) begin
			r[0] = r[0] ^ d.w2;
			r[3] = r[3] ^ LAST_MSG;
		end else if (done == 4 * C_ROUNDS) begin
			r[0] = r[0] ^ LAST_MSG;
			r[2] = r[2] ^ FIN_XOR;
		end
		return r;
	endfunction

endpackage

[rtl/sipmac_if.sv]
// request and response channel interfaces of the siphash mac checker
// depends on sipmac_pkg
interface sipmac_req_if ();
	logic                valid;
	logic                ready;
	sipmac_pkg::req_t    data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sipmac_rsp_if ();
	logic                valid;
	logic                ready;
	sipmac_pkg::rsp_t    data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/sipmac_rem_cell.sv]
// one cell of the session id remainder chain, retires a few dividend bits per cycle
// depends on sipmac_pkg
module sipmac_rem_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [sipmac_pkg::KC_W-1:0]   divisor,
	input  logic                          valid_i,
	input  logic [sipmac_pkg::KC_W-1:0]   rem_i,
	input  sipmac_pkg::req_t              req_i,
	output logic                          valid_o,
	output logic [sipmac_pkg::KC_W-1:0]   rem_o,
	output sipmac_pkg::req_t              req_o
);

	localparam int MSB = sipmac_pkg::SID_W - 1 - CELL_IDX * sipmac_pkg::REM_BITS;

	logic [sipmac_pkg::REM_BITS-1:0] chunk;
	logic [sipmac_pkg::KC_W:0]       trial;
	logic [sipmac_pkg::KC_W-1:0]     rem_next;
	logic                            valid_q;
	logic [sipmac_pkg::KC_W-1:0]     rem_q;
	sipmac_pkg::req_t                req_q;

	// restoring remainder, msb first
	always_comb begin
		chunk    = req_i.header_word0[MSB -: sipmac_pkg::REM_BITS];
		rem_next = rem_i;
		trial    = '0;
		for (int b = sipmac_pkg::REM_BITS - 1; b >= 0; b--) begin
			trial = {rem_next, chunk[b]};
			if (trial >= {1'b0, divisor}) begin
				trial = trial - {1'b0, divisor};
			end
			rem_next = trial[sipmac_pkg::KC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		rem_q <= rem_next;
		req_q <= req_i;
	end

	assign valid_o = valid_q;
	assign rem_o   = rem_q;
	assign req_o   = req_q;

endmodule

[rtl/sipmac_round_cell.sv]
// one cell of the siphash round chain, one full sipround per cycle
// depends on sipmac_pkg
module sipmac_round_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid_i,
	input  sipmac_pkg::sip_state_t  state_i,
	input  sipmac_pkg::side_t       side_i,
	output logic                    valid_o,
	output sipmac_pkg::sip_state_t  state_o,
	output sipmac_pkg::side_t       side_o
);

	logic                   valid_q;
	sipmac_pkg::sip_state_t state_q;
	sipmac_pkg::side_t      side_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		state_q <= sipmac_pkg::sip_round(state_i);
		side_q  <= side_i;
	end

	assign valid_o = valid_q;
	assign state_o = state_q;
	assign side_o  = side_q;

endmodule

[rtl/siphash24_envelope_mac_check.sv]
// siphash-2-4 mac checker over a 24-byte header, keys from a slot table
// a verify result reaches the output fifo after its request is taken, through the
// 8 remainder cells, 1 key table read and 12 round cells; loads give no result
// throughput: one request per cycle while req.ready is high, loads and verifies alike;
// req.ready is low while 32 results are reserved; up to 32 results buffered
// reset: key_count goes to 0, the key table is cleared one slot a cycle with req.ready low
`include "siphash24_envelope_mac_check_defines.svh"
module siphash24_envelope_mac_check #(
	parameter int KEY_SLOTS = sipmac_pkg::KEY_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sipmac_pkg::KC_W-1:0]   cfg_wdata,
	sipmac_req_if.sink                    req,
	sipmac_rsp_if.source                  rsp
);

	localparam int IDX_W    = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
	localparam int PIPE_LAT = sipmac_pkg::REM_CELLS + 1 + sipmac_pkg::ROUNDS;
	localparam int CNT_W    = sipmac_pkg::FIFO_AW + 1;

	logic                        req_fire;
	logic                        vfy_fire;
	logic                        rsp_pop;
	logic [sipmac_pkg::KC_W-1:0] key_count_q;

	// clearing pass
	logic             clr_active_q;
	logic [IDX_W-1:0] clr_addr_q;

	// remainder chain
	logic                        rem_vld [sipmac_pkg::REM_CELLS+1];
	logic [sipmac_pkg::KC_W-1:0] rem_val [sipmac_pkg::REM_CELLS+1];
	sipmac_pkg::req_t            rem_req [sipmac_pkg::REM_CELLS+1];

	// key table access
	logic             m_vld;
	sipmac_pkg::req_t m_req;
	logic [sipmac_pkg::KC_W-1:0] m_rem;
	logic             m_slot_ok;
	logic             m_idx_ok;
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	logic [IDX_W-1:0] mem_ra;
	logic [127:0]     mem_wd;
	logic [127:0]     key_mem [KEY_SLOTS];

	logic             key_valid_s9;
	logic [127:0]     key_rd_s9;
	logic             key_inr_s9;
	logic             key_nok_s9;
	sipmac_pkg::req_t key_req_s9;

	logic [63:0]            k_lo;
	logic [63:0]            k_hi;
	sipmac_pkg::sip_state_t init_st;
	sipmac_pkg::side_t      init_sd;

	// round chain
	logic                   rnd_vld [sipmac_pkg::ROUNDS+1];
	sipmac_pkg::sip_state_t rnd_st  [sipmac_pkg::ROUNDS+1];
	sipmac_pkg::side_t      rnd_sd  [sipmac_pkg::ROUNDS+1];

	sipmac_pkg::sip_state_t fin_st;
	sipmac_pkg::side_t      fin_sd;
	logic [63:0]            fin_tag;
	sipmac_pkg::rsp_t       fin_res;
	logic                   fifo_we;

	// result fifo
	sipmac_pkg::rsp_t             fifo_q [sipmac_pkg::FIFO_DEPTH];
	logic [sipmac_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [sipmac_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [CNT_W-1:0]               fifo_cnt_q;
	logic [CNT_W-1:0]               resv_q;

	assign req_fire = req.valid && req.ready;
	assign vfy_fire = req_fire && (req.data.command == sipmac_pkg::CMD_VERIFY);
	assign rsp_pop  = rsp.valid && rsp.ready;

	// a verify reserves a fifo slot when it enters, so the chain never has to stall
	assign req.ready = !clr_active_q && (resv_q != CNT_W'(sipmac_pkg::FIFO_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q  <= '0;
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else begin
			if (cfg_we) begin
				key_count_q <= cfg_wdata;
			end
			if (clr_active_q) begin
				if (clr_addr_q == IDX_W'(KEY_SLOTS - 1)) begin
					clr_active_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
			end
		end
	end

	assign rem_vld[0] = req_fire;
	assign rem_val[0] = '0;
	assign rem_req[0] = req.data;

	for (genvar i = 0; i < sipmac_pkg::REM_CELLS; i++) begin : g_rem
		sipmac_rem_cell #(
			.CELL_IDX(i)
		) u_rem (
			.clk     (clk),
			.arst_n  (arst_n),
			.divisor (key_count_q),
			.valid_i (rem_vld[i]),
			.rem_i   (rem_val[i]),
			.req_i   (rem_req[i]),
			.valid_o (rem_vld[i+1]),
			.rem_o   (rem_val[i+1]),
			.req_o   (rem_req[i+1])
		);
	end

	// loads write and verifies read at the same stage, so table order follows request order
	always_comb begin
		m_vld     = rem_vld[sipmac_pkg::REM_CELLS];
		m_req     = rem_req[sipmac_pkg::REM_CELLS];
		m_rem     = rem_val[sipmac_pkg::REM_CELLS];
		m_slot_ok = 32'(m_req.key_slot) < KEY_SLOTS;
		m_idx_ok  = 32'(m_rem) < KEY_SLOTS;
		mem_we    = clr_active_q ||
			(m_vld && (m_req.command == sipmac_pkg::CMD_LOAD) && m_slot_ok);
		mem_wa    = clr_active_q ? clr_addr_q : IDX_W'(m_req.key_slot);
		mem_wd    = clr_active_q ? '0 : {m_req.key_high_word, m_req.key_low_word};
		mem_ra    = IDX_W'(m_rem);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[mem_wa] <= mem_wd;
		end
		key_rd_s9 <= key_mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_valid_s9 <= 1'b0;
		end else begin
			key_valid_s9 <= m_vld && (m_req.command == sipmac_pkg::CMD_VERIFY);
		end
	end

	always_ff @(posedge clk) begin
		key_inr_s9 <= m_idx_ok;
		key_nok_s9 <= (key_count_q == '0);
		key_req_s9 <= m_req;
	end

	always_comb begin
		k_lo = key_inr_s9 ? key_rd_s9[63:0]   : '0;
		k_hi = key_inr_s9 ? key_rd_s9[127:64] : '0;
		init_st[0] = k_lo ^ sipmac_pkg::SIP_C0;
		init_st[1] = k_hi ^ sipmac_pkg::SIP_C1;
		init_st[2] = k_lo ^ sipmac_pkg::SIP_C2;
		init_st[3] = k_hi ^ sipmac_pkg::SIP_C3 ^ key_req_s9.header_word0;
		init_sd.nokeys   = key_nok_s9;
		init_sd.zero_key = ((k_lo | k_hi) == '0);
		init_sd.wire_tag = key_req_s9.wire_tag;
		init_sd.w0       = key_req_s9.header_word0;
		init_sd.w1       = key_req_s9.header_word1;
		init_sd.w2       = key_req_s9.header_word2;
	end

	assign rnd_vld[0] = key_valid_s9;
	assign rnd_st[0]  = init_st;
	assign rnd_sd[0]  = init_sd;

	for (genvar i = 0; i < sipmac_pkg::ROUNDS; i++) begin : g_rnd
		sipmac_round_cell u_rnd (
			.clk     (clk),
			.arst_n  (arst_n),
			.valid_i (rnd_vld[i]),
			.state_i (sipmac_pkg::sip_inject(rnd_st[i], rnd_sd[i], i)),
			.side_i  (rnd_sd[i]),
			.valid_o (rnd_vld[i+1]),
			.state_o (rnd_st[i+1]),
			.side_o  (rnd_sd[i+1])
		);
	end

	always_comb begin
		fin_st  = rnd_st[sipmac_pkg::ROUNDS];
		fin_sd  = rnd_sd[sipmac_pkg::ROUNDS];
		fifo_we = rnd_vld[sipmac_pkg::ROUNDS];
		fin_tag = fin_st[0] ^ fin_st[1] ^ fin_st[2] ^ fin_st[3];
		if (fin_sd.nokeys) begin
			fin_res.accept         = 1'b0;
			fin_res.verdict_reason = sipmac_pkg::RSN_NO_KEYS;
			fin_res.computed_tag   = '0;
		end else if (fin_sd.zero_key) begin
			fin_res.accept         = 1'b0;
			fin_res.verdict_reason = sipmac_pkg::RSN_ZERO_KEY;
			fin_res.computed_tag   = '0;
		end else if (fin_tag != fin_sd.wire_tag) begin
			fin_res.accept         = 1'b0;
			fin_res.verdict_reason = sipmac_pkg::RSN_MISMATCH;
			fin_res.computed_tag   = fin_tag;
		end else begin
			fin_res.accept         = 1'b1;
			fin_res.verdict_reason = sipmac_pkg::RSN_OK;
			fin_res.computed_tag   = fin_tag;
		end
	end

	always_ff @(posedge clk) begin
		if (fifo_we) begin
			fifo_q[wr_ptr_q] <= fin_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			resv_q     <= '0;
		end else begin
			if (fifo_we) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rsp_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({fifo_we, rsp_pop})
				2'b10:   fifo_cnt_q <= fifo_cnt_q + 1'b1;
				2'b01:   fifo_cnt_q <= fifo_cnt_q - 1'b1;
				default: fifo_cnt_q <= fifo_cnt_q;
			endcase
			case ({vfy_fire, rsp_pop})
				2'b10:   resv_q <= resv_q + 1'b1;
				2'b01:   resv_q <= resv_q - 1'b1;
				default: resv_q <= resv_q;
			endcase
		end
	end

	assign rsp.valid = (fifo_cnt_q != '0);
	assign rsp.data  = fifo_q[rd_ptr_q];

	`SIPMAC_ASSERT_IMPL(a_fifo_room, fifo_we, (fifo_cnt_q != CNT_W'(sipmac_pkg::FIFO_DEPTH)) || rsp_pop, "result fifo overflow")
	`SIPMAC_ASSERT(a_resv_cover, resv_q >= fifo_cnt_q, "fifo holds more results than were reserved")
	`SIPMAC_ASSERT_IMPL(a_vfy_lat, vfy_fire, ##(PIPE_LAT) fifo_we, "verify result missing at expected stage")
	`SIPMAC_ASSERT_IMPL(a_nokeys, fifo_we && (key_count_q == '0), fin_res.verdict_reason == sipmac_pkg::RSN_NO_KEYS, "zero key count must give no-keys verdict")

endmodule

[dv/sipmac_tag_pkg.sv]
// siphash-2-4 over a fixed 24-byte header, as the testbench computes it
// no dependencies
package sipmac_tag_pkg;

	typedef struct packed {
		logic [63:0] v0;
		logic [63:0] v1;
		logic [63:0] v2;
		logic [63:0] v3;
	} sip_lanes_t;

	// one sipround, rotations spelled out as part-selects
	function automatic sip_lanes_t sip_mix(sip_lanes_t v);
		v.v0 = v.v0 + v.v1;
		v.v1 = {v.v1[50:0], v.v1[63:51]} ^ v.v0;
		v.v0 = {v.v0[31:0], v.v0[63:32]};
		v.v2 = v.v2 + v.v3;
		v.v3 = {v.v3[47:0], v.v3[63:48]} ^ v.v2;
		v.v0 = v.v0 + v.v3;
		v.v3 = {v.v3[42:0], v.v3[63:43]} ^ v.v0;
		v.v2 = v.v2 + v.v1;
		v.v1 = {v.v1[46:0], v.v1[63:47]} ^ v.v2;
		v.v2 = {v.v2[31:0], v.v2[63:32]};
		return v;
	endfunction

	// key[63:0] is key bytes 0..7, key[127:64] bytes 8..15
	function automatic logic [63:0] siphash24_header(logic [127:0] key, logic [63:0] w0,
			logic [63:0] w1, logic [63:0] w2);
		sip_lanes_t v;
		logic [3:0][63:0] blocks;
		v.v0 = key[63:0] ^ 64'h736f6d6570736575;
		v.v1 = key[127:64] ^ 64'h646f72616e646f6d;
		v.v2 = key[63:0] ^ 64'h6c7967656e657261;
		v.v3 = key[127:64] ^ 64'h7465646279746573;
		// last block carries only the length byte, 24 bytes leave no tail
		blocks = {{8'd24, 56'd0}, w2, w1, w0};
		for (int i = 0; i < 4; i++) begin
			v.v3 = v.v3 ^ blocks[i];
			v = sip_mix(sip_mix(v));
			v.v0 = v.v0 ^ blocks[i];
		end
		v.v2 = v.v2 ^ 64'hff;
		for (int i = 0; i < 4; i++)
			v = sip_mix(v);
		return v.v0 ^ v.v1 ^ v.v2 ^ v.v3;
	endfunction

endpackage

[dv/sipmac_verdict_checker.sv]
// watches the key_count port and both channels, predicts each verdict and compares it
// depends on sipmac_pkg, sipmac_if and sipmac_tag_pkg
module sipmac_verdict_checker #(
	parameter int KEY_SLOTS = sipmac_pkg::KEY_SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [sipmac_pkg::KC_W-1:0] cfg_wdata,
	sipmac_req_if                       req,
	sipmac_rsp_if                       rsp,
	output int unsigned                 errors,
	output int unsigned                 awaited,
	output int unsigned                 reason_hits [4]
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDX_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

	logic [127:0]                slot_keys [KEY_SLOTS];
	logic [sipmac_pkg::KC_W-1:0] slots_in_use;
	sipmac_pkg::rsp_t            pending_verdicts [$];

	function automatic sipmac_pkg::rsp_t predict_verdict(sipmac_pkg::req_t r);
		sipmac_pkg::rsp_t v;
		logic [31:0] sel;
		logic [127:0] key;
		v.accept = 1'b0;
		v.verdict_reason = sipmac_pkg::RSN_NO_KEYS;
		v.computed_tag = '0;
		if (slots_in_use == 0)
			return v;
		sel = r.header_word0[31:0] % 32'(slots_in_use);
		key = (sel < KEY_SLOTS) ? slot_keys[IDX_W'(sel)] : '0;
		if (key == '0) begin
			v.verdict_reason = sipmac_pkg::RSN_ZERO_KEY;
			return v;
		end
		v.computed_tag = sipmac_tag_pkg::siphash24_header(key, r.header_word0,
			r.header_word1, r.header_word2);
		v.accept = (v.computed_tag == r.wire_tag);
		v.verdict_reason = v.accept ? sipmac_pkg::RSN_OK : sipmac_pkg::RSN_MISMATCH;
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sipmac_pkg::rsp_t got;
		sipmac_pkg::rsp_t want;
		if (!arst_n) begin
			slot_keys = '{default: '0};
			slots_in_use = '0;
			pending_verdicts.delete();
			errors = 0;
			awaited = 0;
			reason_hits = '{default: 0};
		end else begin
			if (cfg_we)
				slots_in_use = cfg_wdata;
			if (req.valid && req.ready) begin
				if (req.data.command == sipmac_pkg::CMD_LOAD) begin
					if (req.data.key_slot < KEY_SLOTS)
						slot_keys[IDX_W'(req.data.key_slot)] =
							{req.data.key_high_word, req.data.key_low_word};
				end else begin
					pending_verdicts.push_back(predict_verdict(req.data));
				end
			end
			if (rsp.valid && rsp.ready) begin
				got = rsp.data;
				if (pending_verdicts.size() == 0) begin
					errors++;
					$display({"%0t: verdict with none pending, expected nothing, ",
						"got accept %0b reason %0d tag %016h"},
						$time, got.accept, got.verdict_reason, got.computed_tag);
				end else begin
					want = pending_verdicts.pop_front();
					reason_hits[want.verdict_reason]++;
					if (got.accept !== want.accept) begin
						errors++;
						$display("%0t: accept expected %0b actual %0b", $time,
							want.accept, got.accept);
					end
					if (got.verdict_reason !== want.verdict_reason) begin
						errors++;
						$display("%0t: verdict_reason expected %0d actual %0d", $time,
							want.verdict_reason, got.verdict_reason);
					end
					if (got.computed_tag !== want.computed_tag) begin
						errors++;
						$display("%0t: computed_tag expected %016h actual %016h", $time,
							want.computed_tag, got.computed_tag);
					end
				end
			end
			awaited = pending_verdicts.size();
		end
	end

endmodule

[dv/tb_siphash24_envelope_mac_check.sv]
// top of the mac checker testbench: clock, reset, key_count writes, requests, verdict sink
// depends on sipmac_pkg, sipmac_if, sipmac_tag_pkg, sipmac_verdict_checker and the rtl
module tb_siphash24_envelope_mac_check;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          KC_W           = sipmac_pkg::KC_W;
	localparam int unsigned RESET_CYCLES   = 10;
	localparam int unsigned SETTLE_CYCLES  = 40;
	localparam int unsigned SQUEEZE_CYCLES = 400;
	localparam int unsigned CYCLE_LIMIT    = 500000;
	localparam logic [63:0] ALL_ONES       = '1;

	logic            clk = 1'b0;
	logic            arst_n;
	logic            cfg_we;
	logic [KC_W-1:0] cfg_wdata;

	sipmac_req_if req_ch ();
	sipmac_rsp_if rsp_ch ();

	int unsigned check_errors;
	int unsigned awaited;
	int unsigned reason_hits [4];

	// shadow of what was loaded, only used to make matching tags
	logic [127:0]    loaded_keys [256];
	logic [KC_W-1:0] live_count;
	bit              steady;
	bit              squeeze_pending;
	int unsigned     loads_sent;
	int unsigned     verifies_sent;
	int unsigned     settings_used;

	always #2 clk = ~clk;

	siphash24_envelope_mac_check dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	sipmac_verdict_checker u_verdicts (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.errors      (check_errors),
		.awaited     (awaited),
		.reason_hits (reason_hits)
	);

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int unsigned idle_gap();
		int unsigned roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic sipmac_pkg::req_t load_request(logic [7:0] slot, logic [63:0] lo,
			logic [63:0] hi);
		sipmac_pkg::req_t r;
		r.command = sipmac_pkg::CMD_LOAD;
		r.key_slot = slot;
		r.key_low_word = lo;
		r.key_high_word = hi;
		r.wire_tag = rand64();
		r.header_word0 = rand64();
		r.header_word1 = rand64();
		r.header_word2 = rand64();
		return r;
	endfunction

	function automatic sipmac_pkg::req_t verify_request(logic [63:0] w0, logic [63:0] w1,
			logic [63:0] w2, logic [63:0] tag);
		sipmac_pkg::req_t r;
		r.command = sipmac_pkg::CMD_VERIFY;
		r.key_slot = 8'($urandom);
		r.key_low_word = rand64();
		r.key_high_word = rand64();
		r.wire_tag = tag;
		r.header_word0 = w0;
		r.header_word1 = w1;
		r.header_word2 = w2;
		return r;
	endfunction

	function automatic logic [63:0] true_tag(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2);
		logic [31:0] sel;
		if (live_count == 0)
			return '0;
		sel = w0[31:0] % 32'(live_count);
		return sipmac_tag_pkg::siphash24_header(loaded_keys[sel[7:0]], w0, w1, w2);
	endfunction

	// random session id that lands on the given slot under the current key_count
	function automatic logic [31:0] session_for_slot(int unsigned slot);
		logic [63:0] sid;
		sid = {32'd0, $urandom};
		if (live_count == 0)
			return sid[31:0];
		sid = sid - (sid % 64'(live_count)) + 64'(slot);
		if (sid > 64'hFFFF_FFFF)
			sid = sid - 64'(live_count);
		return sid[31:0];
	endfunction

	task automatic send_request(input sipmac_pkg::req_t item);
		int unsigned gap;
		gap = idle_gap();
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.data <= item;
		req_ch.valid <= 1'b1;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (item.command == sipmac_pkg::CMD_LOAD) begin
			loaded_keys[item.key_slot] = {item.key_high_word, item.key_low_word};
			loads_sent++;
		end else begin
			verifies_sent++;
		end
	endtask

	task automatic send_true_verify(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2);
		send_request(verify_request(w0, w1, w2, true_tag(w0, w1, w2)));
	endtask

	// stop offering, wait for every verdict, then let trailing loads leave the pipeline
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_key_count(logic [KC_W-1:0] count);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= count;
		@(posedge clk);
		cfg_we <= 1'b0;
		live_count = count;
		settings_used++;
	endtask

	// response side: random stalls, plus a long hold-off on request
	initial begin : rsp_side
		int unsigned run_len;
		int unsigned stall_len;
		int unsigned held;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (squeeze_pending) begin
				squeeze_pending = 1'b0;
				held = 0;
				rsp_ch.ready <= 1'b0;
				while (held < SQUEEZE_CYCLES) begin
					@(posedge clk);
					held++;
				end
			end
			run_len = $urandom_range(1, 24);
			rsp_ch.ready <= 1'b1;
			repeat (run_len) @(posedge clk);
			stall_len = idle_gap();
			if (stall_len != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		int unsigned phase_counts [11];
		int unsigned hot_slots [$];
		int unsigned slot;
		int unsigned roll;
		logic [63:0] w0;
		logic [63:0] w1;
		logic [63:0] w2;
		logic [63:0] tag;
		logic [127:0] key;

		phase_counts = '{256, 4, 3, 1, 100, 2, 255, 16, 0, 7, 256};
		loaded_keys = '{default: '0};
		live_count = '0;
		steady = 1'b0;
		squeeze_pending = 1'b0;
		loads_sent = 0;
		verifies_sent = 0;
		settings_used = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		// key table clearing pass holds ready low
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);

		// nothing configured: every frame drops
		set_key_count(9'd0);
		send_request(verify_request(64'd0, 64'd0, 64'd0, 64'd0));

		set_key_count(9'd1);
		send_request(verify_request(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
		send_request(load_request(8'd0, ALL_ONES, ALL_ONES));
		send_request(load_request(8'd255, rand64(), rand64()));
		send_true_verify(64'd0, 64'd0, 64'd0);
		send_true_verify(ALL_ONES, ALL_ONES, ALL_ONES);
		send_request(verify_request(64'd0, 64'd0, 64'd0, 64'd0));
		send_request(verify_request(ALL_ONES, 64'd0, ALL_ONES, ALL_ONES));
		// single-bit keys: the lowest bit of the low half, then the top bit of the high half
		send_request(load_request(8'd0, 64'd1, 64'd0));
		send_true_verify(rand64(), rand64(), rand64());
		send_request(load_request(8'd0, 64'd0, 64'h8000_0000_0000_0000));
		send_true_verify(rand64(), rand64(), rand64());

		set_key_count(9'd256);
		send_true_verify({32'h0, 32'd255}, rand64(), rand64());
		send_true_verify(ALL_ONES, rand64(), rand64());
		send_true_verify({$urandom, 32'd1}, rand64(), rand64());
		send_request(load_request(8'd1, 64'd0, 64'd0));
		send_true_verify({32'h0, 32'd1}, rand64(), rand64());
		send_request(load_request(8'd0, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908));
		send_true_verify(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 64'h1716151413121110);

		// count that is not a power of two
		set_key_count(9'd3);
		send_request(load_request(8'd2, rand64(), rand64()));
		send_true_verify({32'h0, 32'hFFFF_FFFF}, rand64(), rand64());
		send_true_verify({32'h0, 32'd5}, rand64(), rand64());

		foreach (phase_counts[p]) begin
			set_key_count(KC_W'(phase_counts[p]));
			steady = (p == 2);
			if (p == 0 || p == 6)
				squeeze_pending = 1'b1;
			hot_slots.delete();
			repeat (12) begin
				slot = (live_count != 0) ? $urandom_range(0, live_count - 1) : $urandom_range(0, 255);
				key = ($urandom_range(0, 99) < 5) ? 128'd0 : {rand64(), rand64()};
				send_request(load_request(8'(slot), key[63:0], key[127:64]));
				hot_slots.push_back(slot);
			end
			repeat (83) begin
				roll = $urandom_range(0, 99);
				if (roll < 15) begin
					key = ($urandom_range(0, 99) < 10) ? 128'd0 : {rand64(), rand64()};
					send_request(load_request(8'($urandom_range(0, 255)), key[63:0], key[127:64]));
				end else begin
					if (roll < 80)
						slot = hot_slots[$urandom_range(0, hot_slots.size() - 1)];
					else
						slot = (live_count != 0) ? $urandom_range(0, live_count - 1) : 0;
					w0 = {$urandom, session_for_slot(slot)};
					w1 = rand64();
					w2 = rand64();
					tag = true_tag(w0, w1, w2);
					roll = $urandom_range(0, 99);
					if (roll >= 90)
						tag = rand64();
					else if (roll >= 70)
						tag = tag ^ (64'd1 << $urandom_range(0, 63));
					send_request(verify_request(w0, w1, w2, tag));
				end
			end
		end
		steady = 1'b0;

		drain();
		$display("covered %0d key loads and %0d frame checks over %0d key_count settings",
			loads_sent, verifies_sent, settings_used);
		$display("verdicts seen: %0d pass, %0d no keys, %0d zero key, %0d tag mismatch",
			reason_hits[sipmac_pkg::RSN_OK], reason_hits[sipmac_pkg::RSN_NO_KEYS],
			reason_hits[sipmac_pkg::RSN_ZERO_KEY], reason_hits[sipmac_pkg::RSN_MISMATCH]);
		if (check_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/sipmac_pkg.sv
rtl/sipmac_if.sv
rtl/sipmac_rem_cell.sv
rtl/sipmac_round_cell.sv
rtl/siphash24_envelope_mac_check.sv
dv/sipmac_tag_pkg.sv
dv/sipmac_verdict_checker.sv
dv/tb_siphash24_envelope_mac_check.sv
